FILE: rtl/core/rud_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register map, configuration struct and offset struct of the
// radial undistortion coordinate map. No dependencies.
package rud_pkg;

  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS  = 8;
  localparam int DIM_BITS   = 14;
  localparam int INV_BITS   = 40;
  localparam int K_BITS     = 32;

  localparam int CFG_DATA_BITS = 40;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [DIM_BITS-1:0] DEF_WIDTH  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] DEF_HEIGHT = DIM_BITS'(480);

  localparam int OUT_BITS = COORD_BITS + FRAC_BITS + 2;

  // Doubled offsets from the center: 2*coord - dim, exact in half pixels.
  localparam int OFS_BITS = ((COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS) + 1;
  localparam int S4_BITS  = 2 * OFS_BITS;

  // Squared radius: split 1/f^2 so each partial product stays narrow.
  localparam int INV_SPLIT   = 20;
  localparam int INV_HI_BITS = INV_BITS - INV_SPLIT;
  localparam int R2_SHIFT    = 18;
  localparam int HI_SHIFT    = INV_SPLIT - R2_SHIFT;
  localparam int PH_BITS     = S4_BITS + INV_HI_BITS;
  localparam int PL_BITS     = S4_BITS + INV_SPLIT;
  localparam int R2_SUM_BITS = PH_BITS + HI_SHIFT + 1;

  localparam int Q_BITS = 32;
  localparam int Q_FRAC = 24;

  // Scale factor, signed with 28 fraction bits.
  localparam int FACTOR_BITS = 40;
  localparam int ONE_SHIFT   = 28;
  localparam int PK_BITS     = K_BITS + Q_BITS + 1;
  localparam int FSUM_BITS   = PK_BITS - Q_FRAC + 2;

  // Source coordinate before saturation.
  localparam int MAP_SHIFT = ONE_SHIFT + 1 - FRAC_BITS;
  localparam int PM_BITS   = OFS_BITS + FACTOR_BITS;
  localparam int SX_BITS   = PM_BITS - MAP_SHIFT + 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INV_FOCAL_SQ = 3'd0,
    REG_K1           = 3'd1,
    REG_K2           = 3'd2,
    REG_WIDTH        = 3'd3,
    REG_HEIGHT       = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        [INV_BITS-1:0] inv_focal_sq;
    logic signed [K_BITS-1:0]   k1;
    logic signed [K_BITS-1:0]   k2;
    logic        [DIM_BITS-1:0] width;
    logic        [DIM_BITS-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic signed [OFS_BITS-1:0] dx2;
    logic signed [OFS_BITS-1:0] dy2;
  } ofs_t;

endpackage

FILE: rtl/core/rud_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the undistortion map: write-only, one index
// per register. Depends on rud_pkg.
module rud_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rud_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [rud_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  output rud_pkg::cfg_t                    cfg_o
);
  import rud_pkg::*;

  cfg_t cfg_q;

  // Drop writes to indexes past the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_focal_sq <= '0;
      cfg_q.k1           <= '0;
      cfg_q.k2           <= '0;
      cfg_q.width        <= DEF_WIDTH;
      cfg_q.height       <= DEF_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INV_FOCAL_SQ: cfg_q.inv_focal_sq <= cfg_wdata_i[INV_BITS-1:0];
        REG_K1:           cfg_q.k1           <= $signed(cfg_wdata_i[K_BITS-1:0]);
        REG_K2:           cfg_q.k2           <= $signed(cfg_wdata_i[K_BITS-1:0]);
        REG_WIDTH:        cfg_q.width        <= cfg_wdata_i[DIM_BITS-1:0];
        REG_HEIGHT:       cfg_q.height       <= cfg_wdata_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/rud_radius.sv
`timescale 1ns / 1ps
// Front of the pipeline: doubled center offsets, squared radius and the
// scaled, saturated r2 (Q8.24). Four register stages. Depends on rud_pkg.
module rud_radius (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rud_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  input  logic [rud_pkg::COORD_BITS-1:0] dest_col_i,
  input  logic [rud_pkg::COORD_BITS-1:0] dest_row_i,
  output logic                          valid_o,
  output rud_pkg::ofs_t                 ofs_o,
  output logic [rud_pkg::Q_BITS-1:0]    r2_o
);
  import rud_pkg::*;

  logic                      v_a_q, v_b_q, v_c_q, v_d_q;
  ofs_t                      ofs_a_d, ofs_a_q, ofs_b_q, ofs_c_q, ofs_d_q;
  logic signed [S4_BITS-1:0] sqx, sqy;
  logic [S4_BITS-1:0]        s4_d, s4_q;
  logic [PH_BITS-1:0]        ph_d, ph_q;
  logic [PL_BITS-1:0]        pl_d, pl_q;
  logic [R2_SUM_BITS-1:0]    r2_sum;
  logic [Q_BITS-1:0]         r2_d, r2_q;

  // Stage A: offsets in half pixels.
  assign ofs_a_d.dx2 = $signed({{(OFS_BITS-COORD_BITS-1){1'b0}}, dest_col_i, 1'b0})
                     - $signed({{(OFS_BITS-DIM_BITS){1'b0}}, cfg_i.width});
  assign ofs_a_d.dy2 = $signed({{(OFS_BITS-COORD_BITS-1){1'b0}}, dest_row_i, 1'b0})
                     - $signed({{(OFS_BITS-DIM_BITS){1'b0}}, cfg_i.height});

  // Stage B: sum of squares.
  assign sqx  = ofs_a_q.dx2 * ofs_a_q.dx2;
  assign sqy  = ofs_a_q.dy2 * ofs_a_q.dy2;
  assign s4_d = $unsigned(sqx) + $unsigned(sqy);

  // Stage C: two partial products against the halves of 1/f^2.
  assign ph_d = s4_q * cfg_i.inv_focal_sq[INV_BITS-1:INV_SPLIT];
  assign pl_d = s4_q * cfg_i.inv_focal_sq[INV_SPLIT-1:0];

  // Stage D: recombine, drop the extra fraction bits, saturate.
  assign r2_sum = (R2_SUM_BITS'(ph_q) << HI_SHIFT) + R2_SUM_BITS'(pl_q >> R2_SHIFT);
  assign r2_d   = (|r2_sum[R2_SUM_BITS-1:Q_BITS]) ? '1 : r2_sum[Q_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      v_a_q <= in_valid_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
      v_d_q <= v_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_a_q <= ofs_a_d;
    ofs_b_q <= ofs_a_q;
    ofs_c_q <= ofs_b_q;
    ofs_d_q <= ofs_c_q;
    s4_q    <= s4_d;
    ph_q    <= ph_d;
    pl_q    <= pl_d;
    r2_q    <= r2_d;
  end

  assign valid_o = v_d_q;
  assign ofs_o   = ofs_d_q;
  assign r2_o    = r2_q;

  a_zero_radius_partials: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_b_q && s4_q == '0) |=> (ph_q == '0 && pl_q == '0))
    else $error("zero radius gave nonzero partial products");

endmodule

FILE: rtl/core/rud_factor.sv
`timescale 1ns / 1ps
// Middle of the pipeline: r4, the two coefficient products and the clamped
// scale factor (Q.28). Three register stages. Depends on rud_pkg.
module rud_factor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rud_pkg::cfg_t                     cfg_i,
  input  logic                              valid_i,
  input  rud_pkg::ofs_t                     ofs_i,
  input  logic [rud_pkg::Q_BITS-1:0]        r2_i,
  output logic                              valid_o,
  output rud_pkg::ofs_t                     ofs_o,
  output logic signed [rud_pkg::FACTOR_BITS-1:0] factor_o
);
  import rud_pkg::*;

  localparam logic signed [FSUM_BITS-1:0]   OneQ      = FSUM_BITS'(64'sd1 <<< ONE_SHIFT);
  localparam logic signed [FACTOR_BITS-1:0] FactorMax = {1'b0, {(FACTOR_BITS-1){1'b1}}};
  localparam logic signed [FACTOR_BITS-1:0] FactorMin = {1'b1, {(FACTOR_BITS-1){1'b0}}};

  logic                            v_e_q, v_f_q, v_g_q;
  ofs_t                            ofs_e_q, ofs_f_q, ofs_g_q;
  logic [2*Q_BITS-1:0]             r2sq_d, r2sq_q;
  logic signed [PK_BITS-1:0]       p1_d, p1_q, p1_f_q;
  logic [Q_BITS-1:0]               r4;
  logic signed [PK_BITS-1:0]       p2_d, p2_q;
  logic signed [PK_BITS-Q_FRAC-1:0] t1, t2;
  logic signed [FSUM_BITS-1:0]     fsum;
  logic [FSUM_BITS-FACTOR_BITS:0]  fsum_top;
  logic signed [FACTOR_BITS-1:0]   factor_d, factor_q;

  // Stage E: r2 squared and k1*r2 side by side.
  assign r2sq_d = r2_i * r2_i;
  assign p1_d   = cfg_i.k1 * $signed({1'b0, r2_i});

  // Stage F: saturated r4, then k2*r4.
  assign r4   = (|r2sq_q[2*Q_BITS-1:Q_BITS+Q_FRAC]) ? '1 : r2sq_q[Q_BITS+Q_FRAC-1:Q_FRAC];
  assign p2_d = cfg_i.k2 * $signed({1'b0, r4});

  // Stage G: floor both terms, add one, clamp.
  assign t1       = p1_f_q[PK_BITS-1:Q_FRAC];
  assign t2       = p2_q[PK_BITS-1:Q_FRAC];
  assign fsum     = OneQ + FSUM_BITS'(t1) + FSUM_BITS'(t2);
  assign fsum_top = fsum[FSUM_BITS-1:FACTOR_BITS-1];

  always_comb begin
    if ((&fsum_top) || !(|fsum_top)) begin
      factor_d = fsum[FACTOR_BITS-1:0];
    end else if (fsum[FSUM_BITS-1]) begin
      factor_d = FactorMin;
    end else begin
      factor_d = FactorMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
      v_g_q <= 1'b0;
    end else begin
      v_e_q <= valid_i;
      v_f_q <= v_e_q;
      v_g_q <= v_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_e_q  <= ofs_i;
    ofs_f_q  <= ofs_e_q;
    ofs_g_q  <= ofs_f_q;
    r2sq_q   <= r2sq_d;
    p1_q     <= p1_d;
    p1_f_q   <= p1_q;
    p2_q     <= p2_d;
    factor_q <= factor_d;
  end

  assign valid_o  = v_g_q;
  assign ofs_o    = ofs_g_q;
  assign factor_o = factor_q;

  a_zero_radius_products: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && r2_i == '0) |=> (p1_q == '0 && r2sq_q == '0))
    else $error("zero radius gave nonzero coefficient products");

endmodule

FILE: rtl/core/rud_map.sv
`timescale 1ns / 1ps
// Back of the pipeline: scale offsets by the factor, add the center back,
// bounds test and saturation. Two register stages. Depends on rud_pkg.
module rud_map (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rud_pkg::cfg_t                          cfg_i,
  input  logic                                   valid_i,
  input  rud_pkg::ofs_t                          ofs_i,
  input  logic signed [rud_pkg::FACTOR_BITS-1:0] factor_i,
  output logic                                   valid_o,
  output logic signed [rud_pkg::OUT_BITS-1:0]    src_col_o,
  output logic signed [rud_pkg::OUT_BITS-1:0]    src_row_o,
  output logic                                   in_bounds_o
);
  import rud_pkg::*;

  localparam logic signed [SX_BITS-1:0]  OneSx  = SX_BITS'(1);
  localparam logic signed [OUT_BITS-1:0] OutMax = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OutMin = {1'b1, {(OUT_BITS-1){1'b0}}};

  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [SX_BITS-1:0] v);
    logic [SX_BITS-OUT_BITS:0] top;
    top = v[SX_BITS-1:OUT_BITS-1];
    if ((&top) || !(|top)) begin
      return v[OUT_BITS-1:0];
    end
    return v[SX_BITS-1] ? OutMin : OutMax;
  endfunction

  logic                                v_h_q, v_i_q;
  logic signed [PM_BITS-1:0]           mx_d, my_d, mx_q, my_q;
  logic signed [PM_BITS-MAP_SHIFT-1:0] mxs, mys;
  logic signed [SX_BITS-1:0]           w_sx, h_sx, bx, by, sx, sy;
  logic                                in_box;
  logic signed [OUT_BITS-1:0]          src_col_q, src_row_q;
  logic                                in_bounds_q;

  // Stage H: scale both offsets.
  assign mx_d = ofs_i.dx2 * factor_i;
  assign my_d = ofs_i.dy2 * factor_i;

  // Stage I: floor shift, add half the dimension, test and saturate.
  assign mxs  = mx_q[PM_BITS-1:MAP_SHIFT];
  assign mys  = my_q[PM_BITS-1:MAP_SHIFT];
  assign w_sx = $signed(SX_BITS'(cfg_i.width));
  assign h_sx = $signed(SX_BITS'(cfg_i.height));
  assign sx   = SX_BITS'(mxs) + (w_sx <<< (FRAC_BITS - 1));
  assign sy   = SX_BITS'(mys) + (h_sx <<< (FRAC_BITS - 1));
  assign bx   = (w_sx - OneSx) <<< FRAC_BITS;
  assign by   = (h_sx - OneSx) <<< FRAC_BITS;
  assign in_box = !sx[SX_BITS-1] && (sx < bx) && !sy[SX_BITS-1] && (sy < by);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_h_q       <= 1'b0;
      v_i_q       <= 1'b0;
      in_bounds_q <= 1'b0;
    end else begin
      v_h_q       <= valid_i;
      v_i_q       <= v_h_q;
      in_bounds_q <= v_h_q && in_box;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q      <= mx_d;
    my_q      <= my_d;
    src_col_q <= sat_out(sx);
    src_row_q <= sat_out(sy);
  end

  assign valid_o     = v_i_q;
  assign src_col_o   = src_col_q;
  assign src_row_o   = src_row_q;
  assign in_bounds_o = in_bounds_q;

  a_inside_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_bounds_o |-> (!src_col_o[OUT_BITS-1] && !src_row_o[OUT_BITS-1]))
    else $error("in-bounds flag on a negative source coordinate");

  a_inside_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_bounds_o |-> $past(v_h_q))
    else $error("in-bounds flag without a beat behind it");

endmodule

FILE: rtl/core/radial_undistort_coordinate_map_unit.sv
`timescale 1ns / 1ps
// Radial lens undistortion coordinate map: destination pixel in, source
// coordinate (8 fraction bits) and in-bounds flag out. Uses rud_pkg,
// rud_cfg_regs, rud_radius, rud_factor and rud_map.
//
// Pipeline: 9 register stages; each accepted beat strobes valid_o for one
// cycle once it has passed through all of them.
// Throughput: one beat per clock, set by the pipeline having a register
// after every multiplier (r2 partials, r2^2 and k1*r2, k2*r4, offset*factor).
// busy_o stays low; the receiver cannot stall, so nothing is held back.
// Reset: rst_ni clears all valid bits and loads the register defaults
// (1/f^2, k1, k2 zero; 640 by 480). No clearing pass is needed.
module radial_undistort_coordinate_map_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [rud_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rud_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // Command side.
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [rud_pkg::COORD_BITS-1:0]     dest_col_i,
  input  logic [rud_pkg::COORD_BITS-1:0]     dest_row_i,
  // Result side.
  output logic                               valid_o,
  output logic signed [rud_pkg::OUT_BITS-1:0] src_col_o,
  output logic signed [rud_pkg::OUT_BITS-1:0] src_row_o,
  output logic                               in_bounds_o
);
  import rud_pkg::*;

  cfg_t                          cfg;
  logic                          accept;
  logic                          rad_valid;
  ofs_t                          rad_ofs;
  logic [Q_BITS-1:0]             rad_r2;
  logic                          fac_valid;
  ofs_t                          fac_ofs;
  logic signed [FACTOR_BITS-1:0] fac_factor;

  // The pipeline advances every cycle, so a new beat is always welcome.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  rud_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Offsets, sum of squares, r2 in Q8.24.
  rud_radius u_radius (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (accept),
    .dest_col_i (dest_col_i),
    .dest_row_i (dest_row_i),
    .valid_o    (rad_valid),
    .ofs_o      (rad_ofs),
    .r2_o       (rad_r2)
  );

  // 1 + k1*r2 + k2*r4, clamped to 40 bits.
  rud_factor u_factor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (rad_valid),
    .ofs_i    (rad_ofs),
    .r2_i     (rad_r2),
    .valid_o  (fac_valid),
    .ofs_o    (fac_ofs),
    .factor_o (fac_factor)
  );

  // Scale, recenter, bounds test, saturate.
  rud_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (fac_valid),
    .ofs_i       (fac_ofs),
    .factor_i    (fac_factor),
    .valid_o     (valid_o),
    .src_col_o   (src_col_o),
    .src_row_o   (src_row_o),
    .in_bounds_o (in_bounds_o)
  );

endmodule
